// File: design/laser_sector_wall_follow_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the laser sector wall follow core
// Implication checks, same cycle and next cycle, reported by $error.
// ---------------------------------------------------------------------------
`ifndef LASER_SECTOR_WALL_FOLLOW_CORE_ASSERT_SVH
`define LASER_SECTOR_WALL_FOLLOW_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LSWF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lswf check failed");

// consequent must hold in the cycle after the antecedent
`define LSWF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lswf check failed");

`endif

// File: design/lswf_pkg.sv
// ---------------------------------------------------------------------------
// lswf_pkg
// Shared types and constants of the laser sector wall follow core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lswf_pkg;

    localparam int DATA_W   = 16;
    localparam int IDX_W    = 10;
    localparam int CFG_W    = 32;
    localparam int ADDR_W   = 5;
    localparam int TURN_W   = 10;
    localparam int SPEED_W  = 9;
    localparam int COS_FRAC = 15;

    localparam int SIDE_WINDOW_DEF  = 6;
    localparam int FRONT_WINDOW_DEF = 11;
    localparam int BEAM_COUNT_DEF   = 1024;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam logic [DATA_W-1:0] RANGE_MIN_RST = 16'd0;
    localparam logic [DATA_W-1:0] RANGE_MAX_RST = 16'd30000;
    localparam logic [DATA_W-1:0] NEAR_RST      = 16'd100;
    localparam logic [DATA_W-1:0] FAR_RST       = 16'd150;
    localparam logic [DATA_W-1:0] COS_RST       = 16'd30382;
    localparam logic [IDX_W-1:0]  LEFT_RST      = 10'd152;
    localparam logic [IDX_W-1:0]  RIGHT_RST     = 10'd22;
    localparam logic [IDX_W-1:0]  FRONT_RST     = 10'd85;

    localparam logic signed [TURN_W-1:0] TURN_LEFT  = -10'sd500;
    localparam logic signed [TURN_W-1:0] TURN_RIGHT = 10'sd500;
    localparam logic signed [TURN_W-1:0] TURN_NONE  = 10'sd0;
    localparam logic [SPEED_W-1:0] SPEED_STOP = 9'd0;
    localparam logic [SPEED_W-1:0] SPEED_NEAR = 9'd100;
    localparam logic [SPEED_W-1:0] SPEED_FWD  = 9'd500;

    typedef enum logic [1:0] {
        STEER_AWAY    = 2'd0,
        STEER_TOWARD  = 2'd1,
        STEER_FORWARD = 2'd2,
        STEER_BLOCKED = 2'd3
    } t_steer;

    typedef enum logic [2:0] {
        REG_RANGE_MIN   = 3'd0,
        REG_RANGE_MAX   = 3'd1,
        REG_NEAR_THRESH = 3'd2,
        REG_FAR_THRESH  = 3'd3,
        REG_SIDE_COS    = 3'd4,
        REG_LEFT_START  = 3'd5,
        REG_RIGHT_START = 3'd6,
        REG_FRONT_START = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_START,
        BK_DIV,
        BK_MUL,
        BK_SCALE,
        BK_STEER,
        BK_OUT
    } t_back_state;

    typedef enum logic [1:0] {
        WIN_LEFT,
        WIN_RIGHT,
        WIN_FRONT
    } t_win;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [DATA_W-1:0] range_min_mm;
        logic [DATA_W-1:0] range_max_mm;
        logic [DATA_W-1:0] near_thresh_mm;
        logic [DATA_W-1:0] far_thresh_mm;
        logic [DATA_W-1:0] side_cos_q15;
        logic [IDX_W-1:0]  left_start;
        logic [IDX_W-1:0]  right_start;
        logic [IDX_W-1:0]  front_start;
    } t_cfg;

    // first member lands in the top bits, so left_dist_mm sits at bit 0
    typedef struct packed {
        logic [SPEED_W-1:0]        speed_mm;
        logic signed [TURN_W-1:0]  turn_rate_mrad;
        t_steer                    steer_code;
        logic                      front_ok;
        logic                      right_ok;
        logic                      left_ok;
        logic [DATA_W-1:0]         front_dist_mm;
        logic [DATA_W-1:0]         right_dist_mm;
        logic [DATA_W-1:0]         left_dist_mm;
    } t_result;

endpackage

// File: design/lswf_front.sv
// ---------------------------------------------------------------------------
// lswf_front
// Beam intake: window hit tests and per-window sum and count accumulation.
// Pushes a snapshot of the accumulators into the queue on the last beam.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lswf_front #(
    parameter int SIDE_WINDOW  = lswf_pkg::SIDE_WINDOW_DEF,
    parameter int FRONT_WINDOW = lswf_pkg::FRONT_WINDOW_DEF,
    parameter int BEAM_COUNT   = lswf_pkg::BEAM_COUNT_DEF,
    parameter int SNAP_W       = 2 * (lswf_pkg::DATA_W + 2 * $clog2(SIDE_WINDOW + 1))
                                 + lswf_pkg::DATA_W + 2 * $clog2(FRONT_WINDOW + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lswf_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lswf_pkg::DATA_W-1:0] i_range,
    input  logic [lswf_pkg::IDX_W-1:0]  i_index,
    input  logic                        i_last,
    input  lswf_pkg::t_q_status         i_q_status,
    output logic                        o_push,
    output logic [SNAP_W-1:0]           o_snap
);

    localparam int SCW = $clog2(SIDE_WINDOW + 1);
    localparam int FCW = $clog2(FRONT_WINDOW + 1);
    localparam int SSW = lswf_pkg::DATA_W + SCW;
    localparam int FSW = lswf_pkg::DATA_W + FCW;
    localparam int XW  = lswf_pkg::IDX_W + 1;

    logic [SSW-1:0] r_left_sum,  n_left_sum;
    logic [SCW-1:0] r_left_cnt,  n_left_cnt;
    logic [SSW-1:0] r_right_sum, n_right_sum;
    logic [SCW-1:0] r_right_cnt, n_right_cnt;
    logic [FSW-1:0] r_front_sum, n_front_sum;
    logic [FCW-1:0] r_front_cnt, n_front_cnt;

    logic          accept;
    logic          sample_ok;
    logic [XW-1:0] idx_x;
    logic          hit_left, hit_right, hit_front;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign idx_x   = XW'(i_index);

    assign sample_ok = (i_range > i_cfg.range_min_mm) && (i_range < i_cfg.range_max_mm)
                       && (idx_x < XW'(BEAM_COUNT));

    // windows do not wrap at the top of the index range
    assign hit_left  = sample_ok && (idx_x >= XW'(i_cfg.left_start))
                       && (idx_x < XW'(i_cfg.left_start) + XW'(SIDE_WINDOW))
                       && (r_left_cnt < SCW'(SIDE_WINDOW));
    assign hit_right = sample_ok && (idx_x >= XW'(i_cfg.right_start))
                       && (idx_x < XW'(i_cfg.right_start) + XW'(SIDE_WINDOW))
                       && (r_right_cnt < SCW'(SIDE_WINDOW));
    assign hit_front = sample_ok && (idx_x >= XW'(i_cfg.front_start))
                       && (idx_x < XW'(i_cfg.front_start) + XW'(FRONT_WINDOW))
                       && (r_front_cnt < FCW'(FRONT_WINDOW));

    always_comb begin
        n_left_sum  = hit_left  ? r_left_sum  + SSW'(i_range) : r_left_sum;
        n_left_cnt  = hit_left  ? r_left_cnt  + SCW'(1)       : r_left_cnt;
        n_right_sum = hit_right ? r_right_sum + SSW'(i_range) : r_right_sum;
        n_right_cnt = hit_right ? r_right_cnt + SCW'(1)       : r_right_cnt;
        n_front_sum = hit_front ? r_front_sum + FSW'(i_range) : r_front_sum;
        n_front_cnt = hit_front ? r_front_cnt + FCW'(1)       : r_front_cnt;
    end

    assign o_push = accept && i_last;
    assign o_snap = {n_front_cnt, n_front_sum, n_right_cnt, n_right_sum,
                     n_left_cnt, n_left_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last)) begin
            r_left_sum  <= '0;
            r_left_cnt  <= '0;
            r_right_sum <= '0;
            r_right_cnt <= '0;
            r_front_sum <= '0;
            r_front_cnt <= '0;
        end else if (accept) begin
            r_left_sum  <= n_left_sum;
            r_left_cnt  <= n_left_cnt;
            r_right_sum <= n_right_sum;
            r_right_cnt <= n_right_cnt;
            r_front_sum <= n_front_sum;
            r_front_cnt <= n_front_cnt;
        end
    end

endmodule

// File: design/lswf_fifo.sv
// ---------------------------------------------------------------------------
// lswf_fifo
// Short snapshot queue between the beam intake and the scan finisher.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lswf_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = lswf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [WIDTH-1:0]    i_data,
    input  logic                i_pop,
    output logic [WIDTH-1:0]    o_data,
    output lswf_pkg::t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: design/lswf_back.sv
// ---------------------------------------------------------------------------
// lswf_back
// Scan finisher: shared restoring divider for the three averages, cosine
// scaling of the sides, steering decision and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lswf_back #(
    parameter int SIDE_WINDOW  = lswf_pkg::SIDE_WINDOW_DEF,
    parameter int FRONT_WINDOW = lswf_pkg::FRONT_WINDOW_DEF,
    parameter int SNAP_W       = 2 * (lswf_pkg::DATA_W + 2 * $clog2(SIDE_WINDOW + 1))
                                 + lswf_pkg::DATA_W + 2 * $clog2(FRONT_WINDOW + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lswf_pkg::t_cfg      i_cfg,
    input  lswf_pkg::t_q_status i_q_status,
    input  logic [SNAP_W-1:0]   i_snap,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output lswf_pkg::t_result   o_result
);

    localparam int DW_ = lswf_pkg::DATA_W;
    localparam int SCW = $clog2(SIDE_WINDOW + 1);
    localparam int FCW = $clog2(FRONT_WINDOW + 1);
    localparam int SSW = DW_ + SCW;
    localparam int FSW = DW_ + FCW;
    localparam int CW  = (SCW > FCW) ? SCW : FCW;
    localparam int QW  = DW_ + CW;
    localparam int STW = $clog2(QW + 1);
    localparam int RB  = SSW + SCW;
    localparam int FB  = 2 * (SSW + SCW);
    localparam int PRW = 2 * DW_;

    lswf_pkg::t_back_state r_state, n_state;
    lswf_pkg::t_win        r_win, n_win;
    logic [STW-1:0]        r_step, n_step;
    logic                  r_valid, n_valid;
    logic [SNAP_W-1:0]     r_snap, n_snap;
    logic [CW-1:0]         r_rem, n_rem;
    logic [QW-1:0]         r_quo, n_quo;
    logic [PRW-1:0]        r_prod, n_prod;
    logic [DW_-1:0]        r_ld, n_ld, r_rd, n_rd, r_fd, n_fd;
    logic                  r_lok, n_lok, r_rok, n_rok, r_fok, n_fok;
    lswf_pkg::t_result     r_result, n_result;

    logic [QW-1:0]  cur_sum;
    logic [CW-1:0]  cur_cnt;
    logic [CW:0]    rem_sh;
    logic           fits;
    logic [CW:0]    rem_sub;
    logic [QW-1:0]  quo_new;
    logic [DW_:0]   scaled;
    logic [DW_-1:0] sat;

    always_comb begin
        case (r_win)
            lswf_pkg::WIN_LEFT: begin
                cur_sum = QW'(r_snap[SSW-1:0]);
                cur_cnt = CW'(r_snap[SSW+SCW-1:SSW]);
            end
            lswf_pkg::WIN_RIGHT: begin
                cur_sum = QW'(r_snap[RB+SSW-1:RB]);
                cur_cnt = CW'(r_snap[RB+SSW+SCW-1:RB+SSW]);
            end
            default: begin
                cur_sum = QW'(r_snap[FB+FSW-1:FB]);
                cur_cnt = CW'(r_snap[FB+FSW+FCW-1:FB+FSW]);
            end
        endcase
    end

    // one quotient bit per cycle, MSB first
    assign rem_sh  = {r_rem, r_quo[QW-1]};
    assign fits    = (rem_sh >= {1'b0, cur_cnt});
    assign rem_sub = fits ? rem_sh - {1'b0, cur_cnt} : rem_sh;
    assign quo_new = {r_quo[QW-2:0], fits};

    assign scaled = r_prod[lswf_pkg::COS_FRAC+DW_:lswf_pkg::COS_FRAC];
    assign sat    = scaled[DW_] ? '1 : scaled[DW_-1:0];

    always_comb begin
        n_state  = r_state;
        n_win    = r_win;
        n_step   = r_step;
        n_valid  = r_valid;
        n_snap   = r_snap;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_prod   = r_prod;
        n_ld     = r_ld;
        n_rd     = r_rd;
        n_fd     = r_fd;
        n_lok    = r_lok;
        n_rok    = r_rok;
        n_fok    = r_fok;
        n_result = r_result;
        o_pop    = 1'b0;
        case (r_state)
            lswf_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_snap  = i_snap;
                    n_win   = lswf_pkg::WIN_LEFT;
                    n_state = lswf_pkg::BK_START;
                end
            end
            lswf_pkg::BK_START: begin
                if (cur_cnt == '0) begin
                    // empty window reports the near threshold
                    case (r_win)
                        lswf_pkg::WIN_LEFT: begin
                            n_ld    = i_cfg.near_thresh_mm;
                            n_lok   = 1'b0;
                            n_win   = lswf_pkg::WIN_RIGHT;
                        end
                        lswf_pkg::WIN_RIGHT: begin
                            n_rd    = i_cfg.near_thresh_mm;
                            n_rok   = 1'b0;
                            n_win   = lswf_pkg::WIN_FRONT;
                        end
                        default: begin
                            n_fd    = i_cfg.near_thresh_mm;
                            n_fok   = 1'b0;
                            n_state = lswf_pkg::BK_STEER;
                        end
                    endcase
                end else begin
                    n_quo   = cur_sum;
                    n_rem   = '0;
                    n_step  = STW'(QW);
                    n_state = lswf_pkg::BK_DIV;
                end
            end
            lswf_pkg::BK_DIV: begin
                n_rem  = rem_sub[CW-1:0];
                n_quo  = quo_new;
                n_step = r_step - STW'(1);
                if (r_step == STW'(1)) begin
                    if (r_win == lswf_pkg::WIN_FRONT) begin
                        n_fd    = quo_new[DW_-1:0];
                        n_fok   = 1'b1;
                        n_state = lswf_pkg::BK_STEER;
                    end else begin
                        n_state = lswf_pkg::BK_MUL;
                    end
                end
            end
            lswf_pkg::BK_MUL: begin
                n_prod  = PRW'(r_quo[DW_-1:0]) * PRW'(i_cfg.side_cos_q15);
                n_state = lswf_pkg::BK_SCALE;
            end
            lswf_pkg::BK_SCALE: begin
                n_state = lswf_pkg::BK_START;
                if (r_win == lswf_pkg::WIN_LEFT) begin
                    n_ld  = sat;
                    n_lok = 1'b1;
                    n_win = lswf_pkg::WIN_RIGHT;
                end else begin
                    n_rd  = sat;
                    n_rok = 1'b1;
                    n_win = lswf_pkg::WIN_FRONT;
                end
            end
            lswf_pkg::BK_STEER: begin
                n_result.left_dist_mm  = r_ld;
                n_result.right_dist_mm = r_rd;
                n_result.front_dist_mm = r_fd;
                n_result.left_ok       = r_lok;
                n_result.right_ok      = r_rok;
                n_result.front_ok      = r_fok;
                if (r_fd > i_cfg.near_thresh_mm) begin
                    if (r_ld < i_cfg.near_thresh_mm) begin
                        n_result.steer_code     = lswf_pkg::STEER_AWAY;
                        n_result.turn_rate_mrad = lswf_pkg::TURN_LEFT;
                        n_result.speed_mm       = lswf_pkg::SPEED_STOP;
                    end else if (r_ld > i_cfg.far_thresh_mm) begin
                        n_result.steer_code     = lswf_pkg::STEER_TOWARD;
                        n_result.turn_rate_mrad = lswf_pkg::TURN_RIGHT;
                        n_result.speed_mm       = lswf_pkg::SPEED_NEAR;
                    end else begin
                        n_result.steer_code     = lswf_pkg::STEER_FORWARD;
                        n_result.turn_rate_mrad = lswf_pkg::TURN_NONE;
                        n_result.speed_mm       = lswf_pkg::SPEED_FWD;
                    end
                end else begin
                    n_result.steer_code     = lswf_pkg::STEER_BLOCKED;
                    n_result.turn_rate_mrad = lswf_pkg::TURN_LEFT;
                    n_result.speed_mm       = lswf_pkg::SPEED_STOP;
                end
                n_valid = 1'b1;
                n_state = lswf_pkg::BK_OUT;
            end
            lswf_pkg::BK_OUT: begin
                if (i_ready) begin
                    n_valid = 1'b0;
                    n_state = lswf_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = lswf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lswf_pkg::BK_IDLE;
            r_win   <= lswf_pkg::WIN_LEFT;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_win   <= n_win;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snap   <= n_snap;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_prod   <= n_prod;
        r_ld     <= n_ld;
        r_rd     <= n_rd;
        r_fd     <= n_fd;
        r_lok    <= n_lok;
        r_rok    <= n_rok;
        r_fok    <= n_fok;
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: design/laser_sector_wall_follow_core.sv
// Throughput: one beam per cycle while the snapshot queue is not full; a new scan
//   is taken from the queue only after the previous result is accepted. Each window mean
//   comes from the shared one-bit-per-cycle restoring divider, whose quotient is 16 + bits of
//   the larger window count wide (20 at default windows); empty windows skip the divider.
// Reset: synchronous, active low; config registers take their defaults, sums clear.
// ---------------------------------------------------------------------------
// laser_sector_wall_follow_core
// Laser scan sector averaging with left-wall-following steering commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module laser_sector_wall_follow_core #(
    parameter int SIDE_WINDOW  = lswf_pkg::SIDE_WINDOW_DEF,
    parameter int FRONT_WINDOW = lswf_pkg::FRONT_WINDOW_DEF,
    parameter int BEAM_COUNT   = lswf_pkg::BEAM_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // beam stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [31:0]                 i_s_tdata,   // range_mm[15:0], beam_index[25:16]
    input  logic                        i_s_tlast,   // last_beam
    // result stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [71:0]                 o_m_tdata,   // left_dist_mm[15:0],
                                                     // right_dist_mm[31:16],
                                                     // front_dist_mm[47:32], left_ok[48],
                                                     // right_ok[49], front_ok[50],
                                                     // steer_code[52:51],
                                                     // turn_rate_mrad[62:53],
                                                     // speed_mm[71:63]
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lswf_pkg::ADDR_W-1:0] paddr,
    input  logic [lswf_pkg::CFG_W-1:0]  pwdata,
    output logic [lswf_pkg::CFG_W-1:0]  prdata,
    output logic                        pready
);

    `include "laser_sector_wall_follow_core_assert.svh"

    localparam int SNAP_W = 2 * (lswf_pkg::DATA_W + 2 * $clog2(SIDE_WINDOW + 1))
                            + lswf_pkg::DATA_W + 2 * $clog2(FRONT_WINDOW + 1);

    lswf_pkg::t_cfg      r_cfg;
    lswf_pkg::t_reg_idx  reg_sel;
    lswf_pkg::t_q_status q_status;
    lswf_pkg::t_result   w_result;
    logic                cfg_wr;
    logic                w_push, w_pop;
    logic [SNAP_W-1:0]   w_snap_in, w_snap_out;

    // ---- configuration registers ----
    assign pready  = 1'b1;
    assign reg_sel = lswf_pkg::t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_min_mm   <= lswf_pkg::RANGE_MIN_RST;
            r_cfg.range_max_mm   <= lswf_pkg::RANGE_MAX_RST;
            r_cfg.near_thresh_mm <= lswf_pkg::NEAR_RST;
            r_cfg.far_thresh_mm  <= lswf_pkg::FAR_RST;
            r_cfg.side_cos_q15   <= lswf_pkg::COS_RST;
            r_cfg.left_start     <= lswf_pkg::LEFT_RST;
            r_cfg.right_start    <= lswf_pkg::RIGHT_RST;
            r_cfg.front_start    <= lswf_pkg::FRONT_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                lswf_pkg::REG_RANGE_MIN:   r_cfg.range_min_mm   <= pwdata[15:0];
                lswf_pkg::REG_RANGE_MAX:   r_cfg.range_max_mm   <= pwdata[15:0];
                lswf_pkg::REG_NEAR_THRESH: r_cfg.near_thresh_mm <= pwdata[15:0];
                lswf_pkg::REG_FAR_THRESH:  r_cfg.far_thresh_mm  <= pwdata[15:0];
                lswf_pkg::REG_SIDE_COS:    r_cfg.side_cos_q15   <= pwdata[15:0];
                lswf_pkg::REG_LEFT_START:  r_cfg.left_start     <= pwdata[9:0];
                lswf_pkg::REG_RIGHT_START: r_cfg.right_start    <= pwdata[9:0];
                lswf_pkg::REG_FRONT_START: r_cfg.front_start    <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            lswf_pkg::REG_RANGE_MIN:   prdata = 32'(r_cfg.range_min_mm);
            lswf_pkg::REG_RANGE_MAX:   prdata = 32'(r_cfg.range_max_mm);
            lswf_pkg::REG_NEAR_THRESH: prdata = 32'(r_cfg.near_thresh_mm);
            lswf_pkg::REG_FAR_THRESH:  prdata = 32'(r_cfg.far_thresh_mm);
            lswf_pkg::REG_SIDE_COS:    prdata = 32'(r_cfg.side_cos_q15);
            lswf_pkg::REG_LEFT_START:  prdata = 32'(r_cfg.left_start);
            lswf_pkg::REG_RIGHT_START: prdata = 32'(r_cfg.right_start);
            lswf_pkg::REG_FRONT_START: prdata = 32'(r_cfg.front_start);
            default:                   prdata = '0;
        endcase
    end

    // ---- datapath ----
    lswf_front #(
        .SIDE_WINDOW  (SIDE_WINDOW),
        .FRONT_WINDOW (FRONT_WINDOW),
        .BEAM_COUNT   (BEAM_COUNT),
        .SNAP_W       (SNAP_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_range    (i_s_tdata[15:0]),
        .i_index    (i_s_tdata[25:16]),
        .i_last     (i_s_tlast),
        .i_q_status (q_status),
        .o_push     (w_push),
        .o_snap     (w_snap_in)
    );

    lswf_fifo #(
        .WIDTH (SNAP_W),
        .DEPTH (lswf_pkg::QUEUE_DEPTH_DEF)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_snap_in),
        .i_pop    (w_pop),
        .o_data   (w_snap_out),
        .o_status (q_status)
    );

    lswf_back #(
        .SIDE_WINDOW  (SIDE_WINDOW),
        .FRONT_WINDOW (FRONT_WINDOW),
        .SNAP_W       (SNAP_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .i_snap     (w_snap_out),
        .o_pop      (w_pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_result   (w_result)
    );

    assign o_m_tdata = w_result;

    // ---- checks ----
    `LSWF_ASSERT_IMP(a_left_empty, i_clk, i_rst_n, o_m_tvalid && !w_result.left_ok, w_result.left_dist_mm == r_cfg.near_thresh_mm)
    `LSWF_ASSERT_IMP(a_front_empty, i_clk, i_rst_n, o_m_tvalid && !w_result.front_ok, w_result.steer_code == lswf_pkg::STEER_BLOCKED)
    `LSWF_ASSERT_IMP(a_forward_cmd, i_clk, i_rst_n, o_m_tvalid && (w_result.steer_code == lswf_pkg::STEER_FORWARD), (w_result.speed_mm == lswf_pkg::SPEED_FWD) && (w_result.turn_rate_mrad == lswf_pkg::TURN_NONE))
    `LSWF_ASSERT_NEXT(a_scan_queued, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tlast, !q_status.empty)

endmodule
